### rtl/core/implicit_list_heap_allocator_unit_macros.svh
// Assertion macros for the implicit-list heap allocator.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Check that is off while reset is asserted.
`define IHLA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("ihla assertion failed");
// Check that also runs through reset.
`define IHLA_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("ihla reset assertion failed");
`else
`define IHLA_ASSERT(lbl, clk, rstn, prop)
`define IHLA_ASSERT_RST(lbl, clk, prop)
`endif
`endif

### rtl/core/ihla_pkg.sv
// Shared types and constants for the implicit-list heap allocator.
// No dependencies.
package ihla_pkg;

    localparam int PTR_W = 8;
    localparam logic [6:0] MAX_PAYLOAD = 7'd126;
    localparam logic [7:0] ID_LIMIT = 8'd255;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_FILL  = 2'd2,
        ACT_QUERY = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADARG   = 3'd1,
        ST_NOSPACE  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_TOOBIG   = 3'd4
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        action_t    action;
        logic [6:0] payload_size;
        logic [7:0] block_id;
        logic [6:0] fill_char;
        logic [6:0] fill_count;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] result_id;
        logic [7:0] header_id;
        logic [7:0] header_size;
    } res_t;

    typedef struct packed {
        alu_op_t          op;
        logic [PTR_W-1:0] a;
        logic [PTR_W-1:0] b;
        logic             cin;
    } alu_req_t;

    typedef struct packed {
        logic [PTR_W-1:0] sum;
        logic             borrow;
    } alu_res_t;

    // Write goes to waddr + wofs; a read returns the byte pair at raddr.
    typedef struct packed {
        logic             we;
        logic             wofs;
        logic [PTR_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } mem_req_t;

endpackage

### rtl/core/implicit_list_heap_allocator_unit.sv
// First-fit implicit-list heap allocator over a byte heap of HEAP_BYTES bytes.
// After reset the unit sweeps the heap once (s_tready low) to lay down a
// single free block. Each command word then runs to completion before the next
// is taken: argument checks, then for each block header passed over a registered
// paired read, a size compare and a pointer add on the one shared adder, a read
// and compare at the header that ends the walk, then two to four header writes
// for allocate, two for free, a size add for query, or a start-address step and
// up to fill_count byte writes for fill, then posting the result and an idle
// state before the next word is taken. Every block spans at least three bytes.
// Results sit in an output register, so a new command is taken while a result
// waits.
// Depends on ihla_pkg, ihla_alu, ihla_heap_mem, ihla_seq and the macro header.
`include "implicit_list_heap_allocator_unit_macros.svh"

module implicit_list_heap_allocator_unit #(
    parameter int HEAP_BYTES = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // payload_size[6:0], block_id[14:7],
                                   // fill_char[21:15], fill_count[28:22], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // status[2:0], result_id[10:3], header_id[18:11],
                                   // header_size[26:19], zero pad
);

    ihla_pkg::cmd_t     cmd;
    ihla_pkg::res_t     seq_res;
    ihla_pkg::mem_req_t mem_req;
    ihla_pkg::alu_req_t alu_req;
    ihla_pkg::alu_res_t alu_res;
    logic [7:0]         rd0;
    logic [7:0]         rd1;
    logic               seq_done;
    logic               out_free;
    logic               m_tvalid_reg;
    logic [31:0]        m_tdata_reg;
    logic               res_failed;

    // unpack the command word
    assign cmd.action       = ihla_pkg::action_t'(s_tuser);
    assign cmd.payload_size = s_tdata[6:0];
    assign cmd.block_id     = s_tdata[14:7];
    assign cmd.fill_char    = s_tdata[21:15];
    assign cmd.fill_count   = s_tdata[28:22];

    assign out_free = !m_tvalid_reg || m_tready;

    ihla_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    ihla_heap_mem #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_mem (
        .aclk (aclk),
        .req  (mem_req),
        .rd0  (rd0),
        .rd1  (rd1)
    );

    ihla_seq #(
        .HEAP_BYTES (HEAP_BYTES)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_tvalid),
        .cmd       (cmd),
        .cmd_ready (s_tready),
        .out_free  (out_free),
        .done      (seq_done),
        .result    (seq_res),
        .mem_req   (mem_req),
        .rd0       (rd0),
        .rd1       (rd1),
        .alu_req   (alu_req),
        .alu_res   (alu_res)
    );

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (seq_done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (seq_done) begin
            m_tdata_reg <= {5'd0, seq_res.header_size, seq_res.header_id,
                            seq_res.result_id, seq_res.status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a posted result word that carries a failing status
    assign res_failed = m_tvalid_reg && (m_tdata_reg[2:0] != ihla_pkg::ST_OK);

    // one command in flight: ready drops right after a command is taken
    `IHLA_ASSERT(a_one_cmd, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready)
    // sequencer never posts into a full result register
    `IHLA_ASSERT(a_done_room, aclk, aresetn, seq_done |-> (!m_tvalid_reg || m_tready))
    // status code stays within the defined set
    `IHLA_ASSERT(a_status_legal, aclk, aresetn, m_tvalid |-> (m_tdata[2:0] <= ihla_pkg::ST_TOOBIG))
    // a failed command carries no ids or size
    `IHLA_ASSERT(a_fail_clean, aclk, aresetn, res_failed |-> (m_tdata[26:3] == 24'd0))
    // reset starts the clearing sweep, so no command is taken next cycle
    `IHLA_ASSERT_RST(a_reset_clear, aclk, !aresetn |=> !s_tready)

endmodule

### rtl/core/ihla_alu.sv
// Shared 8-bit add/subtract unit used by the sequencer.
// Depends on ihla_pkg.
module ihla_alu (
    input  ihla_pkg::alu_req_t req,
    output ihla_pkg::alu_res_t res
);

    logic [ihla_pkg::PTR_W-1:0] b_eff;
    logic                       cin_eff;
    logic [ihla_pkg::PTR_W:0]   total;
    logic                       is_sub;

    assign is_sub  = (req.op == ihla_pkg::ALU_SUB);
    assign b_eff   = is_sub ? ~req.b : req.b;
    assign cin_eff = is_sub ? 1'b1 : req.cin;
    assign total   = {1'b0, req.a} + {1'b0, b_eff}
                   + {{ihla_pkg::PTR_W{1'b0}}, cin_eff};

    assign res.sum    = total[ihla_pkg::PTR_W-1:0];
    assign res.borrow = is_sub & ~total[ihla_pkg::PTR_W];

endmodule

### rtl/core/ihla_heap_mem.sv
// Heap byte store: one write port, one paired read port (bytes a and a+1),
// registered read data. Depends on ihla_pkg.
module ihla_heap_mem #(
    parameter int HEAP_BYTES = 128
) (
    input  logic               aclk,
    input  ihla_pkg::mem_req_t req,
    output logic [7:0]         rd0,
    output logic [7:0]         rd1
);

    localparam int AW = $clog2(HEAP_BYTES);

    logic [7:0]                 mem [HEAP_BYTES];
    logic [ihla_pkg::PTR_W-1:0] wsum;
    logic [ihla_pkg::PTR_W-1:0] rsum;

    assign wsum = req.waddr + {{(ihla_pkg::PTR_W-1){1'b0}}, req.wofs};
    assign rsum = req.raddr + {{(ihla_pkg::PTR_W-1){1'b0}}, 1'b1};

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[wsum[AW-1:0]] <= req.wdata;
        end
        if (req.re) begin
            rd0 <= mem[req.raddr[AW-1:0]];
            rd1 <= mem[rsum[AW-1:0]];
        end
    end

endmodule

### rtl/core/ihla_seq.sv
// Command sequencer: clear pass, header walk, header rewrites, fill loop and size query.
// Drives the shared ALU and the heap store. Depends on ihla_pkg.
module ihla_seq #(
    parameter int HEAP_BYTES = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    input  ihla_pkg::cmd_t     cmd,
    output logic               cmd_ready,
    input  logic               out_free,
    output logic               done,
    output ihla_pkg::res_t     result,
    output ihla_pkg::mem_req_t mem_req,
    input  logic [7:0]         rd0,
    input  logic [7:0]         rd1,
    output ihla_pkg::alu_req_t alu_req,
    input  ihla_pkg::alu_res_t alu_res
);

    localparam int PW = ihla_pkg::PTR_W;
    localparam logic [PW-1:0] LAST_ADDR = PW'(HEAP_BYTES - 1);
    localparam logic [PW-1:0] HEAP_END  = PW'(HEAP_BYTES);
    localparam logic [7:0]    INIT_HDR  = 8'((HEAP_BYTES - 1) * 2);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHECK, S_WALK_RD, S_WALK_CHK, S_WALK_NXT,
        S_A_REM, S_A_HDR, S_A_SPLIT, S_A_TAIL, S_F_CLR, S_F_HDR,
        S_FILL_INIT, S_FILL, S_Q_SIZE, S_DONE
    } state_t;

    state_t               state_reg, state_next;
    ihla_pkg::cmd_t       cmd_reg, cmd_next;
    logic [PW-1:0]        clr_reg, clr_next;
    logic [PW-1:0]        p_reg, p_next;
    logic [PW-1:0]        nm1_reg, nm1_next;
    logic [PW-1:0]        rem_reg, rem_next;
    logic [PW-1:0]        remm1_reg, remm1_next;
    logic [PW-1:0]        q_reg, q_next;
    logic [PW-1:0]        fa_reg, fa_next;
    logic [6:0]           fc_reg, fc_next;
    logic [7:0]           issued_reg, issued_next;
    ihla_pkg::status_t    status_reg, status_next;
    logic [7:0]           rid_reg, rid_next;
    logic [7:0]           hid_reg, hid_next;
    logic [7:0]           hsz_reg, hsz_next;
    logic                 split;

    // Remainder gets its own header only when three or more bytes are left.
    assign split = (rem_reg != '0) && (remm1_reg[PW-1:1] != '0);

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        clr_next    = clr_reg;
        p_next      = p_reg;
        nm1_next    = nm1_reg;
        rem_next    = rem_reg;
        remm1_next  = remm1_reg;
        q_next      = q_reg;
        fa_next     = fa_reg;
        fc_next     = fc_reg;
        issued_next = issued_reg;
        status_next = status_reg;
        rid_next    = rid_reg;
        hid_next    = hid_reg;
        hsz_next    = hsz_reg;
        mem_req     = '0;
        alu_req     = '{op: ihla_pkg::ALU_ADD, a: '0, b: '0, cin: 1'b0};
        cmd_ready   = 1'b0;
        done        = 1'b0;

        case (state_reg)
            S_CLEAR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                mem_req.wdata = (clr_reg == PW'(1)) ? INIT_HDR : 8'd0;
                clr_next      = clr_reg + PW'(1);
                if (clr_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next   = cmd;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // nm1 = need - 1, where need is payload or fill length plus header
                alu_req.a   = (cmd_reg.action == ihla_pkg::ACT_ALLOC)
                            ? {1'b0, cmd_reg.payload_size} : {1'b0, cmd_reg.fill_count};
                alu_req.cin = 1'b1;
                nm1_next    = alu_res.sum;
                status_next = ihla_pkg::ST_OK;
                rid_next    = '0;
                hid_next    = '0;
                hsz_next    = '0;
                p_next      = '0;
                state_next  = S_WALK_RD;
                case (cmd_reg.action)
                    ihla_pkg::ACT_ALLOC: begin
                        if (cmd_reg.payload_size == '0 ||
                            cmd_reg.payload_size > ihla_pkg::MAX_PAYLOAD) begin
                            status_next = ihla_pkg::ST_BADARG;
                            state_next  = S_DONE;
                        end else if (issued_reg >= ihla_pkg::ID_LIMIT) begin
                            status_next = ihla_pkg::ST_NOSPACE;
                            state_next  = S_DONE;
                        end
                    end
                    ihla_pkg::ACT_FILL: begin
                        if (cmd_reg.block_id == '0) begin
                            status_next = ihla_pkg::ST_BADARG;
                            state_next  = S_DONE;
                        end
                    end
                    default: begin
                        if (cmd_reg.block_id == '0 || cmd_reg.block_id > issued_reg) begin
                            status_next = ihla_pkg::ST_BADARG;
                            state_next  = S_DONE;
                        end
                    end
                endcase
            end
            S_WALK_RD: begin
                if (p_reg < LAST_ADDR) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = p_reg;
                    state_next    = S_WALK_CHK;
                end else begin
                    status_next = (cmd_reg.action == ihla_pkg::ACT_ALLOC)
                                ? ihla_pkg::ST_NOSPACE : ihla_pkg::ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end
            S_WALK_CHK: begin
                // size-1 of this block minus need-1
                alu_req.op = ihla_pkg::ALU_SUB;
                alu_req.a  = {1'b0, rd1[7:1]};
                alu_req.b  = nm1_reg;
                rem_next   = alu_res.sum;
                state_next = S_WALK_NXT;
                case (cmd_reg.action)
                    ihla_pkg::ACT_ALLOC: begin
                        if (!rd1[0] && !alu_res.borrow) begin
                            state_next = S_A_REM;
                        end
                    end
                    ihla_pkg::ACT_FREE: begin
                        if (rd0 == cmd_reg.block_id && rd1[0]) begin
                            state_next = S_F_CLR;
                        end
                    end
                    ihla_pkg::ACT_FILL: begin
                        if (rd0 == cmd_reg.block_id) begin
                            if (alu_res.borrow) begin
                                status_next = ihla_pkg::ST_TOOBIG;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_FILL_INIT;
                            end
                        end
                    end
                    default: begin
                        if (rd0 == cmd_reg.block_id) begin
                            state_next = S_Q_SIZE;
                        end
                    end
                endcase
            end
            S_WALK_NXT: begin
                alu_req.a   = p_reg;
                alu_req.b   = {1'b0, rd1[7:1]};
                alu_req.cin = 1'b1;
                p_next      = alu_res.sum;
                state_next  = S_WALK_RD;
            end
            S_A_REM: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = p_reg;
                mem_req.wdata = issued_reg + 8'd1;
                alu_req.op    = ihla_pkg::ALU_SUB;
                alu_req.a     = rem_reg;
                alu_req.b     = PW'(1);
                remm1_next    = alu_res.sum;
                state_next    = S_A_HDR;
            end
            S_A_HDR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = p_reg;
                mem_req.wofs  = 1'b1;
                mem_req.wdata = (rem_reg == '0 || split) ? {nm1_reg[6:0], 1'b1}
                                                         : (rd1 | 8'd1);
                alu_req.a     = p_reg;
                alu_req.b     = nm1_reg;
                alu_req.cin   = 1'b1;
                q_next        = alu_res.sum;
                issued_next   = issued_reg + 8'd1;
                rid_next      = issued_reg + 8'd1;
                state_next    = split ? S_A_SPLIT : S_DONE;
            end
            S_A_SPLIT: begin
                if (q_reg < LAST_ADDR) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = q_reg;
                    mem_req.wdata = 8'd0;
                    state_next    = S_A_TAIL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_A_TAIL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = q_reg;
                mem_req.wofs  = 1'b1;
                mem_req.wdata = {remm1_reg[6:0], 1'b0};
                state_next    = S_DONE;
            end
            S_F_CLR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = p_reg;
                mem_req.wdata = 8'd0;
                state_next    = S_F_HDR;
            end
            S_F_HDR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = p_reg;
                mem_req.wofs  = 1'b1;
                mem_req.wdata = {rd1[7:1], 1'b0};
                rid_next      = cmd_reg.block_id;
                state_next    = S_DONE;
            end
            S_FILL_INIT: begin
                // first payload byte sits two past the header start
                alu_req.a   = p_reg;
                alu_req.b   = PW'(1);
                alu_req.cin = 1'b1;
                fa_next     = alu_res.sum;
                fc_next     = cmd_reg.fill_count;
                state_next  = S_FILL;
            end
            S_FILL: begin
                if (fc_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    mem_req.we    = (fa_reg < HEAP_END);
                    mem_req.waddr = fa_reg;
                    mem_req.wdata = {1'b0, cmd_reg.fill_char};
                    alu_req.a     = fa_reg;
                    alu_req.cin   = 1'b1;
                    fa_next       = alu_res.sum;
                    fc_next       = fc_reg - 7'd1;
                end
            end
            S_Q_SIZE: begin
                alu_req.a   = {1'b0, rd1[7:1]};
                alu_req.cin = 1'b1;
                hsz_next    = alu_res.sum;
                hid_next    = rd0;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            issued_reg <= '0;
        end else begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            issued_reg <= issued_next;
        end
        cmd_reg    <= cmd_next;
        p_reg      <= p_next;
        nm1_reg    <= nm1_next;
        rem_reg    <= rem_next;
        remm1_reg  <= remm1_next;
        q_reg      <= q_next;
        fa_reg     <= fa_next;
        fc_reg     <= fc_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        hid_reg    <= hid_next;
        hsz_reg    <= hsz_next;
    end

    assign result = '{status: status_reg, result_id: rid_reg,
                      header_id: hid_reg, header_size: hsz_reg};

endmodule
